// ===== sv/hsv2bgr_pkg.sv =====
`timescale 1ns / 1ps

package hsv2bgr_pkg;

	// Input field widths
	localparam int HUE_W = 10;
	localparam int PCT_W = 8;
	localparam int BYTE_W = 8;

	// Valid input ranges
	localparam logic [8:0] HUE_MAX = 9'd360;
	localparam logic [6:0] PCT_MAX = 7'd100;

	// Sector boundaries in degrees
	localparam logic [8:0] DEG_60  = 9'd60;
	localparam logic [8:0] DEG_120 = 9'd120;
	localparam logic [8:0] DEG_180 = 9'd180;
	localparam logic [8:0] DEG_240 = 9'd240;
	localparam logic [8:0] DEG_300 = 9'd300;

	// Fixed point: every fraction is over 100 * 100 * 60
	localparam int FRAC_W = 20;
	localparam logic [FRAC_W-1:0] FULL_DEN = 20'd600000;
	localparam logic [FRAC_W-1:0] CHROMA_K = 20'd60;
	localparam logic [FRAC_W-1:0] VALUE_K = 20'd6000;

	// 255 / 600000 = 17 / 40000: times 17, shift by 6, then divide by 625
	// through a reciprocal, exact for any dividend below 2^18
	localparam int DIV_IN_W = 18;
	localparam int PROD_W = 37;
	localparam logic [PROD_W-1:0] RECIP_M = 37'd429497;
	localparam int RECIP_SHIFT = 28;

	// Hue sectors of 60 degrees each
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

// ===== sv/hsv_to_bgr_convert.sv =====
// HSV to BGR colour converter, five-stage pipeline.
// Each accepted item is registered in stages 1 to 5 in order.
// Throughput: one item per cycle while out_stall is low; the five pipeline
// registers each hold one item and advance independently, so a stall only
// backs up into empty slots. Reset (arst_n low, asynchronous) clears the stage
// valid bits only; no payload register is reset.
`timescale 1ns / 1ps

module hsv_to_bgr_convert (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [hsv2bgr_pkg::HUE_W-1:0]   hue,
	input  logic signed [hsv2bgr_pkg::PCT_W-1:0]   saturation,
	input  logic signed [hsv2bgr_pkg::PCT_W-1:0]   brightness,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [hsv2bgr_pkg::BYTE_W-1:0]  blue,
	output logic        [hsv2bgr_pkg::BYTE_W-1:0]  green,
	output logic        [hsv2bgr_pkg::BYTE_W-1:0]  red
);

	import hsv2bgr_pkg::*;

	// Stage valid bits and per-stage advance
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// Stage 1 payload
	logic          ok_s1;
	sector_t       sec_s1;
	logic [13:0]   sv_s1;
	logic [6:0]    val_s1;
	logic [5:0]    ramp_s1;

	// Stage 2 payload
	logic              ok_s2;
	sector_t           sec_s2;
	logic [FRAC_W-1:0] c_s2;
	logic [FRAC_W-1:0] x_s2;
	logic [FRAC_W-1:0] vm_s2;

	// Stage 3 payload: numerators over FULL_DEN
	logic [FRAC_W-1:0] nb_s3, ng_s3, nr_s3;

	// Stage 4 payload: dividends for the divide by 625
	logic [DIV_IN_W-1:0] zb_s4, zg_s4, zr_s4;

	// Stage 5 payload: output bytes
	logic [BYTE_W-1:0] b_s5, g_s5, r_s5;

	// Ready chain: a stage takes a new item when empty or when it moves on
	assign rdy_s5   = !vld_s5 || !out_stall;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- Stage 1: range check, sector, ramp, S*V ----------------
	logic [8:0]  h9;
	logic [6:0]  sat7, val7;
	logic        in_ok;
	sector_t     sec_c;
	logic [8:0]  base_c;
	logic [8:0]  ramp_c;

	assign h9   = hue[8:0];
	assign sat7 = saturation[6:0];
	assign val7 = brightness[6:0];
	assign in_ok = !hue[HUE_W-1] && (h9 <= HUE_MAX)
		&& !saturation[PCT_W-1] && (sat7 <= PCT_MAX)
		&& !brightness[PCT_W-1] && (val7 <= PCT_MAX);

	// Sector from the hue; hue of 360 lands in the last one
	always_comb begin
		if (h9 < DEG_60)       sec_c = SEC_RED_YEL;
		else if (h9 < DEG_120) sec_c = SEC_YEL_GRN;
		else if (h9 < DEG_180) sec_c = SEC_GRN_CYN;
		else if (h9 < DEG_240) sec_c = SEC_CYN_BLU;
		else if (h9 < DEG_300) sec_c = SEC_BLU_MAG;
		else                   sec_c = SEC_MAG_RED;
	end

	// Ramp weight 60 - |(h mod 120) - 60|: rises in even sectors, falls in odd
	always_comb begin
		unique case (sec_c)
			SEC_RED_YEL, SEC_YEL_GRN: base_c = 9'd0;
			SEC_GRN_CYN, SEC_CYN_BLU: base_c = DEG_120;
			SEC_BLU_MAG, SEC_MAG_RED: base_c = DEG_240;
			default:                  base_c = 9'd0;
		endcase
		if (sec_c[0]) ramp_c = base_c + DEG_120 - h9;
		else          ramp_c = h9 - base_c;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ok_s1   <= in_ok;
			sec_s1  <= sec_c;
			sv_s1   <= 14'(sat7) * 14'(val7);
			val_s1  <= val7;
			ramp_s1 <= ramp_c[5:0];
		end
	end

	// ---------------- Stage 2: chroma, ramp and V products ----------------
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			ok_s2  <= ok_s1;
			sec_s2 <= sec_s1;
			c_s2   <= FRAC_W'(sv_s1) * CHROMA_K;
			x_s2   <= FRAC_W'(sv_s1) * FRAC_W'(ramp_s1);
			vm_s2  <= FRAC_W'(val_s1) * VALUE_K;
		end
	end

	// ---------------- Stage 3: offset and channel selection ----------------
	logic [FRAC_W-1:0] m_c;
	logic [FRAC_W-1:0] pb_c, pg_c, pr_c;

	assign m_c = vm_s2 - c_s2;

	always_comb begin
		pb_c = '0;
		pg_c = '0;
		pr_c = '0;
		unique case (sec_s2)
			SEC_RED_YEL: begin pr_c = c_s2; pg_c = x_s2; end
			SEC_YEL_GRN: begin pr_c = x_s2; pg_c = c_s2; end
			SEC_GRN_CYN: begin pg_c = c_s2; pb_c = x_s2; end
			SEC_CYN_BLU: begin pg_c = x_s2; pb_c = c_s2; end
			SEC_BLU_MAG: begin pr_c = x_s2; pb_c = c_s2; end
			SEC_MAG_RED: begin pr_c = c_s2; pb_c = x_s2; end
			default: begin end
		endcase
	end

	// Out-of-range items go black
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			nb_s3 <= ok_s2 ? (pb_c + m_c) : '0;
			ng_s3 <= ok_s2 ? (pg_c + m_c) : '0;
			nr_s3 <= ok_s2 ? (pr_c + m_c) : '0;
		end
	end

	// ---------------- Stage 4: times 17, drop six bits ----------------
	logic [FRAC_W+3:0] yb_c, yg_c, yr_c;

	assign yb_c = {nb_s3, 4'b0000} + {4'b0000, nb_s3};
	assign yg_c = {ng_s3, 4'b0000} + {4'b0000, ng_s3};
	assign yr_c = {nr_s3, 4'b0000} + {4'b0000, nr_s3};

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			zb_s4 <= yb_c[FRAC_W+3 -: DIV_IN_W];
			zg_s4 <= yg_c[FRAC_W+3 -: DIV_IN_W];
			zr_s4 <= yr_c[FRAC_W+3 -: DIV_IN_W];
		end
	end

	// ---------------- Stage 5: divide by 625 via reciprocal ----------------
	logic [PROD_W-1:0] qb_c, qg_c, qr_c;

	assign qb_c = PROD_W'(zb_s4) * RECIP_M;
	assign qg_c = PROD_W'(zg_s4) * RECIP_M;
	assign qr_c = PROD_W'(zr_s4) * RECIP_M;

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			b_s5 <= qb_c[RECIP_SHIFT +: BYTE_W];
			g_s5 <= qg_c[RECIP_SHIFT +: BYTE_W];
			r_s5 <= qr_c[RECIP_SHIFT +: BYTE_W];
		end
	end

	assign out_valid = vld_s5;
	assign blue      = b_s5;
	assign green     = g_s5;
	assign red       = r_s5;

	// ---------------- Checks ----------------
	// A free output means every stage can advance
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	// Offset V - C never goes negative for an in-range item
	a_offset_positive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && ok_s2 |-> vm_s2 >= c_s2)
		else $error("negative offset");

	// Numerators stay within the full denominator
	a_num_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (nb_s3 <= FULL_DEN) && (ng_s3 <= FULL_DEN) && (nr_s3 <= FULL_DEN))
		else $error("channel numerator above full scale");

	// A stalled stage 4 slot keeps its item (blue and red dividends checked)
	a_stage4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !rdy_s4 |=> vld_s4 && $stable(zb_s4) && $stable(zr_s4))
		else $error("stage 4 item lost under stall");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import hsv2bgr_pkg::*;

	// Expected colour for one accepted item, with the item that caused it
	typedef struct {
		logic signed [HUE_W-1:0] hue;
		logic signed [PCT_W-1:0] sat;
		logic signed [PCT_W-1:0] val;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
	} colour_t;

	// Holds the colours still owed by the block and checks each one that comes out
	class bgr_scoreboard;
		colour_t colour_q[$];
		int mismatches = 0;

		function automatic logic [BYTE_W-1:0] frac_to_byte(input int unsigned num);
			return BYTE_W'((255 * num) / 600000);
		endfunction

		// Exact fixed-point HSV to BGR, all fractions over 100 * 100 * 60
		function automatic colour_t convert(input logic signed [HUE_W-1:0] h,
				input logic signed [PCT_W-1:0] s, input logic signed [PCT_W-1:0] v);
			colour_t col;
			int hi, si, vi;
			int unsigned chroma, ramp, offs, t, d, pr, pg, pb;
			sector_t sec;
			col.hue = h;
			col.sat = s;
			col.val = v;
			hi = h;
			si = s;
			vi = v;
			if (hi < 0 || hi > int'(HUE_MAX) || si < 0 || si > int'(PCT_MAX) ||
					vi < 0 || vi > int'(PCT_MAX)) begin
				// out of range: black
				col.blue = '0;
				col.green = '0;
				col.red = '0;
				return col;
			end
			chroma = 60 * si * vi;
			t = hi % 120;
			d = (t >= 60) ? (t - 60) : (60 - t);
			ramp = si * vi * (60 - d);
			offs = 60 * vi * (100 - si);
			if (hi < 60) sec = SEC_RED_YEL;
			else if (hi < 120) sec = SEC_YEL_GRN;
			else if (hi < 180) sec = SEC_GRN_CYN;
			else if (hi < 240) sec = SEC_CYN_BLU;
			else if (hi < 300) sec = SEC_BLU_MAG;
			else sec = SEC_MAG_RED;   // 360 lands here with zero ramp
			case (sec)
				SEC_RED_YEL: begin pr = chroma; pg = ramp;   pb = 0;      end
				SEC_YEL_GRN: begin pr = ramp;   pg = chroma; pb = 0;      end
				SEC_GRN_CYN: begin pr = 0;      pg = chroma; pb = ramp;   end
				SEC_CYN_BLU: begin pr = 0;      pg = ramp;   pb = chroma; end
				SEC_BLU_MAG: begin pr = ramp;   pg = 0;      pb = chroma; end
				default:     begin pr = chroma; pg = 0;      pb = ramp;   end
			endcase
			col.blue = frac_to_byte(pb + offs);
			col.green = frac_to_byte(pg + offs);
			col.red = frac_to_byte(pr + offs);
			return col;
		endfunction

		function void note_input(input logic signed [HUE_W-1:0] h,
				input logic signed [PCT_W-1:0] s, input logic signed [PCT_W-1:0] v);
			colour_q.insert(colour_q.size(), convert(h, s, v));
		endfunction

		function int pending();
			return colour_q.size();
		endfunction

		task report(input string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] g,
				input logic [BYTE_W-1:0] r);
			colour_t exp_col;
			string tag;
			if (colour_q.size() == 0) begin
				report($sformatf("colour b=%0d g=%0d r=%0d with no item pending", b, g, r));
				return;
			end
			exp_col = colour_q.pop_front();
			tag = $sformatf("h=%0d s=%0d v=%0d", exp_col.hue, exp_col.sat, exp_col.val);
			if (b !== exp_col.blue)
				report($sformatf("%s blue %0d, want %0d", tag, b, exp_col.blue));
			if (g !== exp_col.green)
				report($sformatf("%s green %0d, want %0d", tag, g, exp_col.green));
			if (r !== exp_col.red)
				report($sformatf("%s red %0d, want %0d", tag, r, exp_col.red));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [HUE_W-1:0] hue;
	logic signed [PCT_W-1:0] saturation;
	logic signed [PCT_W-1:0] brightness;
	logic out_valid;
	logic out_stall;
	logic [BYTE_W-1:0] blue;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] red;

	bgr_scoreboard book = new();
	bit gaps_on = 1'b1;

	hsv_to_bgr_convert dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blue       (blue),
		.green      (green),
		.red        (red)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Offer one item, idling at random first, and hold it until taken
	task automatic send_item(input logic signed [HUE_W-1:0] h,
			input logic signed [PCT_W-1:0] s, input logic signed [PCT_W-1:0] v);
		while (gaps_on && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			hue <= HUE_W'($urandom());
			saturation <= PCT_W'($urandom());
			brightness <= PCT_W'($urandom());
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		book.note_input(h, s, v);
	endtask

	// Mostly in-range colours, some with one field wild, some fully random
	task automatic send_random();
		int pick;
		logic signed [HUE_W-1:0] h;
		logic signed [PCT_W-1:0] s, v;
		pick = $urandom_range(0, 99);
		h = HUE_W'($urandom_range(0, 360));
		s = PCT_W'($urandom_range(0, 100));
		v = PCT_W'($urandom_range(0, 100));
		if (pick < 10) begin
			case ($urandom_range(0, 2))
				0: h = HUE_W'($urandom());
				1: s = PCT_W'($urandom());
				default: v = PCT_W'($urandom());
			endcase
		end else if (pick < 20) begin
			h = HUE_W'($urandom());
			s = PCT_W'($urandom());
			v = PCT_W'($urandom());
		end
		send_item(h, s, v);
	endtask

	// Let the sender rest until the block has handed back everything
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
	endtask

	// Receiver: check taken colours, stall at random
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				book.check_result(blue, green, red);
			out_stall <= gaps_on ? ($urandom_range(0, 99) < 20) : 1'b0;
		end
	end

	// Stimulus
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		hue <= '0;
		saturation <= '0;
		brightness <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sector starts, 360 and the last degree of each sector
		send_item(0, 100, 100);
		send_item(60, 100, 100);
		send_item(120, 100, 100);
		send_item(180, 100, 100);
		send_item(240, 100, 100);
		send_item(300, 100, 100);
		send_item(360, 100, 100);
		send_item(59, 100, 100);
		send_item(119, 100, 100);
		send_item(179, 100, 100);
		send_item(239, 100, 100);
		send_item(299, 100, 100);
		send_item(359, 100, 100);
		// black, grey, a mid colour
		send_item(0, 0, 0);
		send_item(200, 0, 100);
		send_item(30, 50, 50);
		// each field just past and far past its range
		send_item(361, 50, 50);
		send_item(-1, 50, 50);
		send_item(511, 100, 100);
		send_item(-512, 100, 100);
		send_item(90, 101, 50);
		send_item(90, -128, 50);
		send_item(90, 127, 50);
		send_item(90, 50, -1);
		send_item(90, 50, 127);
		send_item(90, 50, -128);

		repeat (350) send_random();
		// full rate, no gaps on either side
		gaps_on = 1'b0;
		repeat (350) send_random();
		gaps_on = 1'b1;
		drain();
		repeat (400) send_random();

		drain();
		repeat (10) @(posedge clk);
		if (book.mismatches == 0 && book.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
